[rtl/core/mmb_pkg.sv]
// Shared types, constants and helper functions of the model matrix builder.
`timescale 1ns / 1ps
package mmb_pkg;

  localparam int TRIG_ITERATIONS_DEF = 16;
  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam int IN_DATA_W  = 280;  // 273 payload bits padded to whole bytes
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int DS_STEPS    = 32;  // result bits of the divide / square-root unit

  localparam logic [15:0] ANG_FULL    = 16'd46080;
  localparam logic [15:0] ANG_HALF    = 16'd23040;
  localparam logic [15:0] ANG_QUARTER = 16'd11520;
  localparam logic [15:0] SCALE_MIN   = 16'd1638;
  localparam logic [15:0] SCALE_MAX   = 16'd32768;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

  localparam logic [4:0] NORMAL_BASE = 5'd16;
  localparam logic [4:0] LAST_ELEM   = 5'd24;

  typedef enum logic [0:0] {
    DS_DIV,
    DS_SQRT
  } ds_mode_t;

  typedef struct packed {
    logic        start;
    ds_mode_t    mode;
    logic [63:0] num;
    logic [31:0] den;
  } ds_req_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] org;
    logic [2:0][15:0] axis;
    logic [15:0]      ang;    // saturated, 0..46080
    logic [15:0]      scale;  // saturated, 1638..32768
    logic [31:0]      norm2;  // squared axis length
    logic             axis_err;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_UDIV,
    ST_CORDIC,
    ST_MULR,
    ST_RSUM,
    ST_MULM,
    ST_MULT,
    ST_NDIV,
    ST_EMIT
  } back_state_t;

  // atan(2^-i) in units of 2^-23 degree
  function automatic logic [29:0] atan_lut(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd377487360;
      5'd1:  v = 30'd222843801;
      5'd2:  v = 30'd117744544;
      5'd3:  v = 30'd59768969;
      5'd4:  v = 30'd30000467;
      5'd5:  v = 30'd15014858;
      5'd6:  v = 30'd7509261;
      5'd7:  v = 30'd3754860;
      5'd8:  v = 30'd1877459;
      5'd9:  v = 30'd938733;
      5'd10: v = 30'd469367;
      5'd11: v = 30'd234683;
      5'd12: v = 30'd117342;
      5'd13: v = 30'd58671;
      5'd14: v = 30'd29335;
      5'd15: v = 30'd14668;
      5'd16: v = 30'd7334;
      5'd17: v = 30'd3667;
      5'd18: v = 30'd1833;
      5'd19: v = 30'd917;
      5'd20: v = 30'd458;
      5'd21: v = 30'd229;
      5'd22: v = 30'd115;
      5'd23: v = 30'd57;
      5'd24: v = 30'd29;
      5'd25: v = 30'd14;
      5'd26: v = 30'd7;
      5'd27: v = 30'd4;
      5'd28: v = 30'd2;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/mmb_front.sv]
// Input stage: unpacks a word, saturates angle and scale, flags a zero axis.
`timescale 1ns / 1ps
module mmb_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mmb_pkg::IN_DATA_W-1:0] s_tdata,
  output logic                          item_valid,
  input  logic                          item_ready,
  output mmb_pkg::item_t                item
);

  logic signed [15:0] ax, ay, az;
  logic signed [31:0] sqx, sqy, sqz;
  logic [32:0]        n2_sum;
  logic [16:0]        ang_raw;
  logic [15:0]        sc_raw;
  logic [15:0]        ang_sat;
  logic [15:0]        sc_sat;
  mmb_pkg::item_t     item_next;
  logic               accept;

  assign ax      = s_tdata[207:192];
  assign ay      = s_tdata[223:208];
  assign az      = s_tdata[239:224];
  assign ang_raw = s_tdata[256:240];
  assign sc_raw  = s_tdata[272:257];

  assign sqx    = ax * ax;
  assign sqy    = ay * ay;
  assign sqz    = az * az;
  assign n2_sum = 33'(unsigned'(sqx)) + 33'(unsigned'(sqy)) + 33'(unsigned'(sqz));

  always_comb begin
    if (ang_raw[16]) begin
      ang_sat = 16'd0;
    end else if (ang_raw[15:0] > mmb_pkg::ANG_FULL) begin
      ang_sat = mmb_pkg::ANG_FULL;
    end else begin
      ang_sat = ang_raw[15:0];
    end
    if (sc_raw < mmb_pkg::SCALE_MIN) begin
      sc_sat = mmb_pkg::SCALE_MIN;
    end else if (sc_raw > mmb_pkg::SCALE_MAX) begin
      sc_sat = mmb_pkg::SCALE_MAX;
    end else begin
      sc_sat = sc_raw;
    end
  end

  always_comb begin
    item_next.pos[0]  = s_tdata[31:0];
    item_next.pos[1]  = s_tdata[63:32];
    item_next.pos[2]  = s_tdata[95:64];
    item_next.org[0]  = s_tdata[127:96];
    item_next.org[1]  = s_tdata[159:128];
    item_next.org[2]  = s_tdata[191:160];
    item_next.axis[0] = ax;
    item_next.axis[1] = ay;
    item_next.axis[2] = az;
    item_next.ang     = ang_sat;
    item_next.scale   = sc_sat;
    item_next.norm2   = n2_sum[31:0];
    item_next.axis_err = (n2_sum == 33'd0);
  end

  assign s_tready = !item_valid || item_ready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

[rtl/core/mmb_queue.sv]
// Short FIFO between the input stage and the compute engine.
`timescale 1ns / 1ps
module mmb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mmb_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output mmb_pkg::item_t out_item
);

  localparam int Depth = mmb_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(Depth);

  mmb_pkg::item_t  slots [Depth];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            push;
  logic            pop;

  assign in_ready  = (count != (AW+1)'(Depth));
  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

[rtl/core/mmb_divsqrt.sv]
// Shared radix-2 unit: restoring divide or integer square root, one bit a cycle.
`timescale 1ns / 1ps
module mmb_divsqrt (
  input  logic             clk,
  input  logic             rst,
  input  mmb_pkg::ds_req_t req,
  output logic             done,
  output logic [31:0]      result
);

  localparam logic [4:0]  LastStep = 5'(mmb_pkg::DS_STEPS - 1);
  localparam logic [63:0] SqrtBit  = 64'h4000_0000_0000_0000;

  logic              busy;
  logic [4:0]        cnt;
  mmb_pkg::ds_mode_t mode_q;
  logic [63:0]       rem;
  logic [63:0]       dsh;
  logic [63:0]       acc;
  logic [63:0]       trial;
  logic              ge;
  logic [63:0]       rem_next;
  logic [63:0]       acc_next;

  always_comb begin
    trial    = (mode_q == mmb_pkg::DS_SQRT) ? acc + dsh : dsh;
    ge       = (rem >= trial);
    rem_next = ge ? rem - trial : rem;
    if (mode_q == mmb_pkg::DS_SQRT) begin
      acc_next = ge ? (acc >> 1) + dsh : (acc >> 1);
    end else begin
      acc_next = {acc[62:0], ge};
    end
  end

  assign result = acc[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode_q <= req.mode;
      rem    <= req.num;
      acc    <= '0;
      dsh    <= (req.mode == mmb_pkg::DS_SQRT) ? SqrtBit : {1'b0, req.den, 31'd0};
    end else if (busy) begin
      rem <= rem_next;
      acc <= acc_next;
      dsh <= (mode_q == mmb_pkg::DS_SQRT) ? (dsh >> 2) : (dsh >> 1);
    end
  end

endmodule

[rtl/core/mmb_back.sv]
// Compute engine: axis normalize, CORDIC, matrix products, normal divides, word output.
`timescale 1ns / 1ps
module mmb_back #(
  parameter int TRIG_ITERATIONS = mmb_pkg::TRIG_ITERATIONS_DEF,
  parameter int COORD_FRAC_BITS = mmb_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  mmb_pkg::item_t                 item,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mmb_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [mmb_pkg::OUT_USER_W-1:0] m_tuser,
  output logic                           m_tlast
);

  localparam logic [5:0]        CordLast = 6'(TRIG_ITERATIONS - 1);
  localparam int                Msh      = 30 - COORD_FRAC_BITS;
  localparam logic signed [39:0] OneCoord = 40'sd1 <<< COORD_FRAC_BITS;
  localparam logic signed [39:0] MRound   = 40'sd1 <<< (Msh - 1);

  mmb_pkg::back_state_t state, state_next;

  // control
  logic [3:0] j;
  logic [1:0] col_q, row_q;
  logic [4:0] elem;
  logic       ds_busy;
  logic       ds_done;
  logic [31:0] ds_q;
  mmb_pkg::ds_req_t ds_req;
  logic       step_adv;
  logic       out_load;

  // payload
  mmb_pkg::item_t     cur;
  logic [31:0]        len_q;
  logic signed [33:0] u_q  [3];
  logic signed [33:0] t_q  [3];
  logic signed [33:0] tu_q [9];
  logic signed [33:0] su_q [3];
  logic signed [33:0] r_q  [9];
  logic signed [33:0] m_q  [9];
  logic signed [33:0] n_q  [9];
  logic signed [37:0] tr_q [3];
  logic signed [33:0] cx, cy;
  logic signed [31:0] cz;
  logic               cneg;
  logic [5:0]         citer;

  // cordic helpers
  logic signed [17:0] aw0, aw1;
  logic               aneg;
  logic signed [33:0] xs, ys;
  logic signed [31:0] atan_s;
  logic signed [33:0] c_val, s_val, one_minus_c;

  // multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic signed [67:0] rnd30_w, rnd14_w;

  // reads
  logic [3:0]         jr;
  logic signed [33:0] r_sel;
  logic [33:0]        r_abs;
  logic [3:0]         m_rd;
  logic signed [33:0] m_sel;
  logic signed [16:0] ax_sel;
  logic [16:0]        ax_abs;

  // output word
  logic [1:0]         e_col, e_row, tr_row;
  logic [3:0]         n_idx;
  logic signed [39:0] trans_v;
  logic signed [39:0] elem_v;
  logic [31:0]        elem_sat;

  mmb_divsqrt u_divsqrt (
    .clk    (clk),
    .rst    (rst),
    .req    (ds_req),
    .done   (ds_done),
    .result (ds_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mmb_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = item.axis_err ? mmb_pkg::ST_MULM : mmb_pkg::ST_SQRT;
        end
      end
      mmb_pkg::ST_SQRT: begin
        if (ds_done) state_next = mmb_pkg::ST_UDIV;
      end
      mmb_pkg::ST_UDIV: begin
        if (ds_done && j == 4'd2) state_next = mmb_pkg::ST_CORDIC;
      end
      mmb_pkg::ST_CORDIC: begin
        if (citer == CordLast) state_next = mmb_pkg::ST_MULR;
      end
      mmb_pkg::ST_MULR: begin
        if (j == 4'd14) state_next = mmb_pkg::ST_RSUM;
      end
      mmb_pkg::ST_RSUM: state_next = mmb_pkg::ST_MULM;
      mmb_pkg::ST_MULM: begin
        if (j == 4'd8) state_next = mmb_pkg::ST_MULT;
      end
      mmb_pkg::ST_MULT: begin
        if (j == 4'd8) state_next = mmb_pkg::ST_NDIV;
      end
      mmb_pkg::ST_NDIV: begin
        if (ds_done && j == 4'd8) state_next = mmb_pkg::ST_EMIT;
      end
      mmb_pkg::ST_EMIT: begin
        if (out_load && elem == mmb_pkg::LAST_ELEM) state_next = mmb_pkg::ST_IDLE;
      end
      default: state_next = mmb_pkg::ST_IDLE;
    endcase
  end

  // state machine outputs
  always_comb begin
    item_ready = 1'b0;
    out_load   = 1'b0;
    step_adv   = 1'b0;
    ds_req.start = 1'b0;
    ds_req.mode  = mmb_pkg::DS_DIV;
    ds_req.num   = '0;
    ds_req.den   = '0;
    unique case (state)
      mmb_pkg::ST_IDLE: item_ready = 1'b1;
      mmb_pkg::ST_SQRT: begin
        ds_req.start = !ds_busy;
        ds_req.mode  = mmb_pkg::DS_SQRT;
        ds_req.num   = 64'(cur.norm2) << 28;
      end
      mmb_pkg::ST_UDIV: begin
        ds_req.start = !ds_busy;
        ds_req.num   = (64'(ax_abs) << 44) + 64'(len_q >> 1);
        ds_req.den   = len_q;
        step_adv     = ds_done;
      end
      mmb_pkg::ST_NDIV: begin
        ds_req.start = !ds_busy;
        ds_req.num   = (64'(r_abs) << COORD_FRAC_BITS) + (64'(cur.scale) << 15);
        ds_req.den   = 32'(cur.scale) << 16;
        step_adv     = ds_done;
      end
      mmb_pkg::ST_MULR, mmb_pkg::ST_MULM, mmb_pkg::ST_MULT: step_adv = 1'b1;
      mmb_pkg::ST_EMIT: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // angle folded into -90..90 degrees before the CORDIC
  always_comb begin
    aw0  = $signed({2'b00, item.ang});
    if (aw0 > $signed({2'b00, mmb_pkg::ANG_HALF})) begin
      aw0 = aw0 - $signed({2'b00, mmb_pkg::ANG_FULL});
    end
    aw1  = aw0;
    aneg = 1'b0;
    if (aw0 > $signed({2'b00, mmb_pkg::ANG_QUARTER})) begin
      aw1  = aw0 - $signed({2'b00, mmb_pkg::ANG_HALF});
      aneg = 1'b1;
    end else if (aw0 < -$signed({2'b00, mmb_pkg::ANG_QUARTER})) begin
      aw1  = aw0 + $signed({2'b00, mmb_pkg::ANG_HALF});
      aneg = 1'b1;
    end
  end

  assign xs          = cx >>> citer;
  assign ys          = cy >>> citer;
  assign atan_s      = $signed({2'b00, mmb_pkg::atan_lut(citer[4:0])});
  assign c_val       = cneg ? -cx : cx;
  assign s_val       = cneg ? -cy : cy;
  assign one_minus_c = mmb_pkg::ONE_Q30 - c_val;

  // operand reads
  assign jr     = (j > 4'd8) ? 4'd0 : j;
  assign r_sel  = r_q[jr];
  assign r_abs  = r_sel[33] ? 34'(-r_sel) : 34'(r_sel);
  assign ax_sel = 17'($signed(cur.axis[(j > 4'd2) ? 2'd0 : j[1:0]]));
  assign ax_abs = ax_sel[16] ? 17'(-ax_sel) : 17'(ax_sel);

  assign e_col  = elem[3:2];
  assign e_row  = elem[1:0];
  assign tr_row = (e_row == 2'd3) ? 2'd0 : e_row;

  always_comb begin
    if (state == mmb_pkg::ST_EMIT) begin
      if (e_col == 2'd3 || e_row == 2'd3 || elem >= mmb_pkg::NORMAL_BASE) begin
        m_rd = 4'd0;
      end else begin
        m_rd = 4'({e_col, 1'b0}) + 4'(e_col) + 4'(e_row);
      end
    end else begin
      m_rd = jr;
    end
  end
  assign m_sel = m_q[m_rd];

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      mmb_pkg::ST_MULR: begin
        unique case (j)
          4'd0:  begin mul_a = one_minus_c; mul_b = u_q[0]; end
          4'd1:  begin mul_a = one_minus_c; mul_b = u_q[1]; end
          4'd2:  begin mul_a = one_minus_c; mul_b = u_q[2]; end
          4'd3:  begin mul_a = t_q[0]; mul_b = u_q[0]; end
          4'd4:  begin mul_a = t_q[0]; mul_b = u_q[1]; end
          4'd5:  begin mul_a = t_q[0]; mul_b = u_q[2]; end
          4'd6:  begin mul_a = t_q[1]; mul_b = u_q[0]; end
          4'd7:  begin mul_a = t_q[1]; mul_b = u_q[1]; end
          4'd8:  begin mul_a = t_q[1]; mul_b = u_q[2]; end
          4'd9:  begin mul_a = t_q[2]; mul_b = u_q[0]; end
          4'd10: begin mul_a = t_q[2]; mul_b = u_q[1]; end
          4'd11: begin mul_a = t_q[2]; mul_b = u_q[2]; end
          4'd12: begin mul_a = s_val; mul_b = u_q[0]; end
          4'd13: begin mul_a = s_val; mul_b = u_q[1]; end
          4'd14: begin mul_a = s_val; mul_b = u_q[2]; end
          default: ;
        endcase
      end
      mmb_pkg::ST_MULM: begin
        mul_a = r_sel;
        mul_b = $signed({18'd0, cur.scale});
      end
      mmb_pkg::ST_MULT: begin
        mul_a = m_sel;
        mul_b = 34'($signed(cur.org[(col_q == 2'd3) ? 2'd0 : col_q]));
      end
      default: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign rnd30_w = (prod + (68'sd1 <<< 29)) >>> 30;
  assign rnd14_w = (prod + (68'sd1 <<< 13)) >>> 14;

  // output word value
  always_comb begin
    trans_v = 40'($signed(cur.pos[tr_row])) + 40'($signed(cur.org[tr_row]))
              - 40'(tr_q[tr_row]);
    n_idx   = (elem >= mmb_pkg::NORMAL_BASE) ? 4'(elem - mmb_pkg::NORMAL_BASE) : 4'd0;
    if (elem >= mmb_pkg::NORMAL_BASE) begin
      elem_v = 40'(n_q[n_idx]);
    end else if (e_col == 2'd3) begin
      elem_v = (e_row == 2'd3) ? OneCoord : trans_v;
    end else if (e_row == 2'd3) begin
      elem_v = '0;
    end else begin
      elem_v = (40'(m_sel) + MRound) >>> Msh;
    end
    elem_sat = mmb_pkg::sat32(elem_v);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mmb_pkg::ST_IDLE;
      j        <= '0;
      col_q    <= '0;
      row_q    <= '0;
      elem     <= '0;
      ds_busy  <= 1'b0;
      citer    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state != state_next) begin
        j     <= '0;
        col_q <= '0;
        row_q <= '0;
      end else if (step_adv) begin
        j <= j + 1'b1;
        if (row_q == 2'd2) begin
          row_q <= '0;
          col_q <= col_q + 1'b1;
        end else begin
          row_q <= row_q + 1'b1;
        end
      end
      if (ds_req.start) begin
        ds_busy <= 1'b1;
      end else if (ds_done) begin
        ds_busy <= 1'b0;
      end
      if (state == mmb_pkg::ST_IDLE) begin
        citer <= '0;
      end else if (state == mmb_pkg::ST_CORDIC) begin
        citer <= citer + 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
        elem     <= (elem == mmb_pkg::LAST_ELEM) ? 5'd0 : elem + 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      mmb_pkg::ST_IDLE: begin
        if (item_valid) begin
          cur  <= item;
          cx   <= mmb_pkg::CORDIC_GAIN;
          cy   <= '0;
          cz   <= 32'(aw1) <<< 16;
          cneg <= aneg;
          for (int k = 0; k < 9; k++) begin
            r_q[k] <= (k == 0 || k == 4 || k == 8) ? mmb_pkg::ONE_Q30 : 34'sd0;
          end
        end
      end
      mmb_pkg::ST_SQRT: begin
        if (ds_done) len_q <= ds_q;
      end
      mmb_pkg::ST_UDIV: begin
        if (ds_done) begin
          u_q[(j > 4'd2) ? 2'd0 : j[1:0]] <=
            ax_sel[16] ? -$signed({2'b00, ds_q}) : $signed({2'b00, ds_q});
        end
      end
      mmb_pkg::ST_CORDIC: begin
        if (cz >= 0) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atan_s;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atan_s;
        end
      end
      mmb_pkg::ST_MULR: begin
        if (j < 4'd3) begin
          t_q[j[1:0]] <= rnd30_w[33:0];
        end else if (j < 4'd12) begin
          tu_q[4'(j - 4'd3)] <= rnd30_w[33:0];
        end else begin
          su_q[2'(j - 4'd12)] <= rnd30_w[33:0];
        end
      end
      mmb_pkg::ST_RSUM: begin
        r_q[0] <= c_val + tu_q[0];
        r_q[1] <= tu_q[1] + su_q[2];
        r_q[2] <= tu_q[2] - su_q[1];
        r_q[3] <= tu_q[3] - su_q[2];
        r_q[4] <= c_val + tu_q[4];
        r_q[5] <= tu_q[5] + su_q[0];
        r_q[6] <= tu_q[6] + su_q[1];
        r_q[7] <= tu_q[7] - su_q[0];
        r_q[8] <= c_val + tu_q[8];
      end
      mmb_pkg::ST_MULM: begin
        m_q[jr] <= rnd14_w[33:0];
      end
      mmb_pkg::ST_MULT: begin
        tr_q[(row_q == 2'd3) ? 2'd0 : row_q] <=
          ((col_q == 2'd0) ? 38'sd0 : tr_q[(row_q == 2'd3) ? 2'd0 : row_q])
          + rnd30_w[37:0];
      end
      mmb_pkg::ST_NDIV: begin
        if (ds_done) begin
          n_q[jr] <= r_sel[33] ? -$signed({2'b00, ds_q}) : $signed({2'b00, ds_q});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= elem_sat;
      m_tuser <= {1'b0, cur.axis_err, (elem >= mmb_pkg::NORMAL_BASE), elem};
      m_tlast <= (elem == mmb_pkg::LAST_ELEM);
    end
  end

endmodule

[rtl/core/model_matrix_builder.sv]
// Top level of the model matrix builder: input stage, item queue, compute engine.
`timescale 1ns / 1ps
// Usage:
//   Slave channel s_*: one word per placement (position, pivot origin, rotation
//   axis, angle, scale). Master channel m_*: a run of 25 words per placement,
//   the 16 model matrix entries then the 9 normal matrix entries, column-major;
//   m_tlast marks the final word of the run.
//   The input stage registers and classifies a word (angle and scale clamp,
//   zero-axis check), then hands it to a two-entry queue, so new words are taken
//   while the engine is busy or the receiver stalls.
//   The engine runs one placement at a time. Its cost is set by the shared
//   divide / square-root unit, one result bit per cycle: 13 operations
//   (square root, 3 axis divides, 9 normal divides), plus TRIG_ITERATIONS
//   CORDIC iterations, 33 multiply steps, a sum, the idle state and 25 output
//   words; a zero axis skips the normalize and rotation.
//   A stalled receiver holds the output register; the engine waits on it, and
//   the queue fills and then deasserts s_tready.
//   Reset (rst, synchronous) empties the input stage, queue and output and
//   returns the engine to idle.
module model_matrix_builder #(
  parameter int TRIG_ITERATIONS = mmb_pkg::TRIG_ITERATIONS_DEF,
  parameter int COORD_FRAC_BITS = mmb_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pos_x, pos_y, pos_z, origin_x, origin_y, origin_z, axis_x, axis_y, axis_z,
  // angle_degrees, scale_value, zero pad
  input  logic [mmb_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // element_value
  output logic [mmb_pkg::OUT_DATA_W-1:0] m_tdata,
  // element_index [4:0], is_normal_matrix [5], axis_error [6], zero pad [7]
  output logic [mmb_pkg::OUT_USER_W-1:0] m_tuser,
  output logic                           m_tlast
);

  mmb_pkg::item_t front_item;
  mmb_pkg::item_t queue_item;
  logic           front_valid;
  logic           front_ready;
  logic           queue_valid;
  logic           queue_ready;

  mmb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  mmb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_item  (queue_item)
  );

  mmb_back #(
    .TRIG_ITERATIONS (TRIG_ITERATIONS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .item       (queue_item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule
